// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the rtl top level rgb_to_hsl_converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HSL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define HSL_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define HSL_ASSERT(label, clk, rst_n, prop)
`define HSL_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/hsl_pkg.sv -----
// types and constants of the rgb to hsl converter
`timescale 1ns / 1ps
package hsl_pkg;

  localparam int unsigned DivStages = 16;
  localparam int unsigned NumW      = 25;
  localparam int unsigned DenW      = 9;
  localparam logic [14:0] HueFull   = 15'd23040;
  localparam logic [11:0] HueScale  = 12'd3840;
  localparam logic [15:0] Unit      = 16'd65535;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [NumW-1:0] hue_num;
    logic [DenW-1:0] hue_den;
    logic [NumW-1:0] sat_num;
    logic [DenW-1:0] sat_den;
    logic [15:0]     light;
  } front_t;

endpackage

// ----- rtl/core/hsl_front.sv -----
// max/min stage that forms dividends, divisors and the lightness
`timescale 1ns / 1ps
module hsl_front (
  input  logic                clk_i,
  input  logic                en_i,
  input  hsl_pkg::pix_t       pix_i,
  output hsl_pkg::front_t     front_o
);

  logic [7:0]  r, g, b, mx, mn;
  logic [8:0]  sum;
  logic [7:0]  diff;
  logic [11:0] num;
  logic [8:0]  sden;
  hsl_pkg::front_t front_d, front_q;

  always_comb begin
    r = pix_i.red;
    g = pix_i.green;
    b = pix_i.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    sum  = {1'b0, mx} + {1'b0, mn};
    diff = mx - mn;
    if (b == mx) begin
      num = ({4'd0, diff} << 2) + {4'd0, r} - {4'd0, g};
    end else if (g == mx) begin
      num = ({4'd0, diff} << 1) + {4'd0, b} - {4'd0, r};
    end else begin
      num = ({4'd0, diff} << 2) + ({4'd0, diff} << 1) + {4'd0, g} - {4'd0, b};
    end
    sden = (sum <= 9'd255) ? sum : (9'd510 - sum);
    if (diff == 8'd0) begin
      front_d.hue_num = '0;
      front_d.hue_den = 9'd1;
      front_d.sat_num = '0;
      front_d.sat_den = 9'd1;
    end else begin
      front_d.hue_num = {13'd0, hsl_pkg::HueScale} * {13'd0, num};
      front_d.hue_den = {1'b0, diff};
      front_d.sat_num = {9'd0, hsl_pkg::Unit} * {17'd0, diff};
      front_d.sat_den = sden;
    end
    // sum * 65535 / 510 is exactly 128 * sum + sum / 2
    front_d.light = {sum, 7'd0} + {8'd0, sum[8:1]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ----- rtl/core/hsl_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module hsl_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [hsl_pkg::NumW-1:0]      num_i,
  input  logic [hsl_pkg::DenW-1:0]      den_i,
  output logic [15:0]                   quo_o
);

  logic [hsl_pkg::DenW-1:0] rem_q [hsl_pkg::DivStages];
  logic [hsl_pkg::DenW-1:0] den_q [hsl_pkg::DivStages];
  logic [15:0]              low_q [hsl_pkg::DivStages];
  logic [15:0]              quo_q [hsl_pkg::DivStages];

  for (genvar s = 0; s < hsl_pkg::DivStages; s++) begin : g_stage
    logic [hsl_pkg::DenW-1:0] rem_in, den_in;
    logic [15:0]              low_in, quo_in;
    logic [hsl_pkg::DenW:0]   trial;
    logic                     ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i[hsl_pkg::NumW-1:16];
      assign low_in = num_i[15:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, low_in[15]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? hsl_pkg::DenW'(trial - {1'b0, den_in})
                       : hsl_pkg::DenW'(trial);
        low_q[s] <= {low_in[14:0], 1'b0};
        quo_q[s] <= {quo_in[14:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[hsl_pkg::DivStages-1];

endmodule

// ----- rtl/core/rgb_to_hsl_converter.sv -----
// top level of the rgb to hsl converter
//
//  channel  | valid       | ready        | payload
//  in       | in_valid_i  | in_ready_o   | in_data_i   (hsl_pkg::pix_t)
//  out      | out_valid_o | out_ready_i  | out_data_o  (hsl_pkg::hsl_t)
//
// one item per cycle while the output is not stalled; an accepted pixel passes
// pix_q, the front register, the 16 stage dividers (one quotient bit each), out_q
// reset clears only the valid bits, no clearing pass
// a stall on the output freezes the whole pipeline, in_ready_o drops with it
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgb_to_hsl_converter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hsl_pkg::pix_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hsl_pkg::hsl_t   out_data_o
);

  localparam int unsigned Depth = hsl_pkg::DivStages + 2;

  logic            en;
  logic [Depth-1:0] vld_q;
  logic            out_valid_q;
  hsl_pkg::pix_t   pix_q;
  hsl_pkg::front_t front;
  hsl_pkg::hsl_t   out_d, out_q;
  logic [15:0]     hue_quo, sat_quo;
  logic [15:0]     light_q [hsl_pkg::DivStages];

  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Depth-2:0], in_valid_i};
      out_valid_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q <= in_data_i;
      out_q <= out_d;
    end
  end

  // lightness waits beside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      light_q[0] <= front.light;
      for (int unsigned i = 1; i < hsl_pkg::DivStages; i++) begin
        light_q[i] <= light_q[i-1];
      end
    end
  end

  hsl_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .pix_i   (pix_q),
    .front_o (front)
  );

  hsl_div u_div_hue (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (front.hue_num),
    .den_i (front.hue_den),
    .quo_o (hue_quo)
  );

  hsl_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (front.sat_num),
    .den_i (front.sat_den),
    .quo_o (sat_quo)
  );

  always_comb begin
    if (hue_quo > {1'b0, hsl_pkg::HueFull}) begin
      out_d.hue = 15'(hue_quo - {1'b0, hsl_pkg::HueFull});
    end else begin
      out_d.hue = hue_quo[14:0];
    end
    out_d.saturation = sat_quo;
    out_d.lightness  = light_q[hsl_pkg::DivStages-1];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HSL_NEVER(a_hue_range, clk_i, rst_ni, out_valid_o && (out_data_o.hue > hsl_pkg::HueFull))
  `HSL_ASSERT(a_ready_rule, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))
  `HSL_ASSERT(a_hold_on_stall, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> $stable(vld_q))

endmodule

// ----- sim/rgb_to_hsl_converter_tb.sv -----
// testbench of the rgb to hsl converter: directed and random pixels checked against a predictor
`timescale 1ns / 1ps
module rgb_to_hsl_converter_tb;

  class hsl_scoreboard;
    hsl_pkg::hsl_t pending[$];
    int   errors;
    int   checked;

    function hsl_pkg::hsl_t convert(hsl_pkg::pix_t p);
      hsl_pkg::hsl_t res;
      int unsigned r, g, b, mx, mn, sum, diff, num, hue, sat, light;
      r = p.red;
      g = p.green;
      b = p.blue;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      sum = mx + mn;
      diff = mx - mn;
      hue = 0;
      sat = 0;
      if (diff != 0) begin
        if (b == mx) num = 4 * diff + r - g;
        else if (g == mx) num = 2 * diff + b - r;
        else num = 6 * diff + g - b;
        hue = (3840 * num) / diff;
        if (hue > 23040) hue -= 23040;
        if (sum <= 255) sat = (65535 * diff) / sum;
        else sat = (65535 * diff) / (510 - sum);
      end
      light = (sum * 65535) / 510;
      res.hue = hue[14:0];
      res.saturation = sat[15:0];
      res.lightness = light[15:0];
      return res;
    endfunction

    function void note_pixel(hsl_pkg::pix_t p);
      pending.push_back(convert(p));
    endfunction

    function void check_result(hsl_pkg::hsl_t got);
      hsl_pkg::hsl_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hue !== want.hue) begin
        $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $display("%0t: saturation expected %0d actual %0d", $time, want.saturation,
                 got.saturation);
        errors++;
      end
      if (got.lightness !== want.lightness) begin
        $display("%0t: lightness expected %0d actual %0d", $time, want.lightness,
                 got.lightness);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  hsl_pkg::pix_t in_data_i;
  hsl_pkg::hsl_t out_data_o;
  hsl_scoreboard sb;
  int   sent;
  bit   hold_off;

  rgb_to_hsl_converter dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_pixel(hsl_pkg::pix_t p, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(p);
    sent++;
  endtask

  function automatic hsl_pkg::pix_t mk(int r, int g, int b);
    hsl_pkg::pix_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    return p;
  endfunction

  function automatic hsl_pkg::pix_t rand_pixel();
    hsl_pkg::pix_t p;
    int c;
    p = 24'($urandom);
    c = $urandom_range(0, 7);
    if (c == 0) begin
      p.green = p.red;
      p.blue = p.red;
    end else if (c == 1) p.green = p.blue;
    else if (c == 2) p.red = p.green;
    else if (c == 3) p.red = p.blue;
    return p;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin : receiver
    int n;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_off = 0;
      end
      n = (sent > 200 && sent < 400) ? 0 : gap_len();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int w;
    sb = new();
    sent = 0;
    hold_off = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pixel(mk(0, 0, 0), 0);
    send_pixel(mk(255, 255, 255), 0);
    send_pixel(mk(128, 128, 128), 0);
    send_pixel(mk(255, 0, 0), 0);
    send_pixel(mk(0, 255, 0), 0);
    send_pixel(mk(0, 0, 255), 0);
    send_pixel(mk(255, 0, 1), 0);
    send_pixel(mk(255, 255, 0), 0);
    send_pixel(mk(0, 255, 255), 0);
    send_pixel(mk(255, 0, 255), 0);
    send_pixel(mk(1, 0, 0), 0);
    send_pixel(mk(255, 254, 254), 0);
    send_pixel(mk(128, 127, 127), 0);
    send_pixel(mk(127, 128, 128), 0);
    send_pixel(mk(200, 100, 50), 0);
    send_pixel(mk(50, 100, 200), 0);
    send_pixel(mk(100, 200, 50), 0);
    send_pixel(mk(170, 85, 170), 0);
    send_pixel(mk(0, 1, 255), 0);
    send_pixel(mk(255, 1, 0), 0);
    for (int i = 0; i < 1350; i++) begin
      if (i == 600) hold_off = 1;
      send_pixel(rand_pixel(), !(i >= 180 && i < 380) && !(i >= 600 && i < 700));
    end
    in_valid_i <= 1'b0;
    w = 0;
    while (sb.pending.size() != 0 && w < 100000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (40) @(posedge clk_i);
    $display("checked %0d results from %0d pixels, gray, ties, extremes and random colors",
             sb.checked, sent);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/hsl_pkg.sv
rtl/core/hsl_front.sv
rtl/core/hsl_div.sv
rtl/core/rgb_to_hsl_converter.sv
sim/rgb_to_hsl_converter_tb.sv
